### hw/rtl/mbc_pkg.sv
// shared types, s-box tables and round helpers for the magma block cipher
package mbc_pkg;

	localparam int unsigned ROUNDS    = 32;
	localparam int unsigned ROT       = 11;
	localparam int unsigned HALF_W    = 32;
	localparam int unsigned NUM_KEYS  = 8;
	localparam int unsigned NUM_REGS  = 4;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned FWD_ROUNDS = 24;

	// register indexes on the configuration port
	localparam logic [1:0] REG_KEY_255_192 = 2'd0;
	localparam logic [1:0] REG_KEY_191_128 = 2'd1;
	localparam logic [1:0] REG_KEY_127_64  = 2'd2;
	localparam logic [1:0] REG_KEY_63_0    = 2'd3;

	localparam logic [3:0] SBOX [8][16] = '{
		'{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
		  4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
		'{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
		  4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
		'{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
		'{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
		  4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
		'{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
		  4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
		'{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
		  4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
		'{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
		  4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
		'{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
		  4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
	};

	typedef logic [NUM_KEYS-1:0][HALF_W-1:0] round_keys_t;

	// one pipeline slot between two round cells
	typedef struct packed {
		logic              vld;
		logic              dec;
		logic [HALF_W-1:0] a1;
		logic [HALF_W-1:0] a0;
	} mbc_stage_t;

	// zero-based key slot used in encryption round r
	function automatic logic [2:0] enc_key_idx(input int unsigned r);
		logic [2:0] low;
		low = 3'(r % NUM_KEYS);
		if (r < FWD_ROUNDS) begin
			return low;
		end
		return 3'(NUM_KEYS - 1) - low;
	endfunction

	// add key, substitute nibbles, rotate left
	function automatic logic [HALF_W-1:0] g_func(input logic [HALF_W-1:0] a,
			input logic [HALF_W-1:0] k);
		logic [HALF_W-1:0] s;
		logic [HALF_W-1:0] t;
		s = a + k;
		for (int i = 0; i < 8; i++) begin
			t[4*i +: 4] = SBOX[i][s[4*i +: 4]];
		end
		return {t[HALF_W-1-ROT:0], t[HALF_W-1:HALF_W-ROT]};
	endfunction

endpackage

### hw/rtl/mbc_round.sv
// one feistel round cell with its output register
module mbc_round import mbc_pkg::*; #(
	parameter int unsigned ROUND = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  round_keys_t keys,
	input  mbc_stage_t  stg_in,
	output mbc_stage_t  stg_out
);

	localparam logic [2:0] ENC_IDX = enc_key_idx(ROUND);
	localparam logic [2:0] DEC_IDX = enc_key_idx(ROUNDS - 1 - ROUND);
	localparam bit         LAST    = (ROUND == ROUNDS - 1);

	logic [HALF_W-1:0] rk;
	logic [HALF_W-1:0] f;
	mbc_stage_t        stg_q;

	assign rk = stg_in.dec ? keys[DEC_IDX] : keys[ENC_IDX];
	assign f  = g_func(stg_in.a0, rk) ^ stg_in.a1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q <= '0;
		end else begin
			stg_q.vld <= stg_in.vld;
			stg_q.dec <= stg_in.dec;
			if (LAST) begin
				// final round keeps the halves in place
				stg_q.a1 <= f;
				stg_q.a0 <= stg_in.a0;
			end else begin
				stg_q.a1 <= stg_in.a0;
				stg_q.a0 <= f;
			end
		end
	end

	assign stg_out = stg_q;

endmodule

### hw/rtl/magma_block_cipher_64.sv
// magma 64-bit block cipher: key registers and a chain of 32 round cells
// a start transfer passes through the round cell registers in order to the done strobe
// throughput: one block per cycle, busy stays low, one cell per round
// result is shown for exactly one cycle on done, the receiver cannot stall
// reset clears the key registers to zero and empties the round chain
module magma_block_cipher_64 import mbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [63:0]        block_in,
	input  logic               decrypt,
	output logic               done,
	output logic [63:0]        block_out
);

	logic [NUM_REGS-1:0][63:0] key_q;
	logic [1:0]                reg_idx;
	logic                      wr_en;
	round_keys_t               keys;
	mbc_stage_t                stg [0:ROUNDS];

	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign busy    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_KEY_255_192: key_q[0] <= pwdata;
				REG_KEY_191_128: key_q[1] <= pwdata;
				REG_KEY_127_64:  key_q[2] <= pwdata;
				REG_KEY_63_0:    key_q[3] <= pwdata;
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KEY_255_192: prdata = key_q[0];
			REG_KEY_191_128: prdata = key_q[1];
			REG_KEY_127_64:  prdata = key_q[2];
			REG_KEY_63_0:    prdata = key_q[3];
			default:         prdata = '0;
		endcase
	end

	// K1 is the high word of the first register, K8 the low word of the last
	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			keys[2*i]     = key_q[i][63:32];
			keys[2*i + 1] = key_q[i][31:0];
		end
	end

	assign stg[0].vld = start && !busy;
	assign stg[0].dec = decrypt;
	assign stg[0].a1  = block_in[63:32];
	assign stg[0].a0  = block_in[31:0];

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		mbc_round #(
			.ROUND(r)
		) u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.keys   (keys),
			.stg_in (stg[r]),
			.stg_out(stg[r+1])
		);
	end

	assign done      = stg[ROUNDS].vld;
	assign block_out = {stg[ROUNDS].a1, stg[ROUNDS].a0};

	// every accepted block reaches the done output at the end of the round chain
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##32 done)
		else $error("accepted block did not reach the output in time");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 32))
		else $error("done strobe without a matching start transfer");

	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && reg_idx == REG_KEY_63_0 |=> key_q[3] == $past(pwdata))
		else $error("key write transfer not stored");

	a_dec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##32 stg[ROUNDS].dec == $past(decrypt, 32))
		else $error("direction bit lost in the round chain");

endmodule
